@@ hdl/ngns_pkg.sv @@
// Package for the navigation grid neighbour store.
// Holds the item types, op codes, register indexes, sequencer states and the
// neighbour step table. Depends on nothing.
package ngns_pkg;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic               new_walkable;
    logic [15:0]        new_cost;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        cell_walkable;
    logic [15:0] cell_cost;
    logic        found;
    logic [5:0]  neighbor_x;
    logic [5:0]  neighbor_y;
    logic        last;
    logic [63:0] revision;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_READ       = 3'd0,
    OP_WRITE_CELL = 3'd1,
    OP_WRITE_WALK = 3'd2,
    OP_WRITE_COST = 3'd3,
    OP_NEIGHBORS  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_GRID_HEIGHT    = 2'd1,
    REG_EIGHT_WAY      = 2'd2,
    REG_CORNER_CUTTING = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_NREAD,
    ST_NCOLLECT,
    ST_NEMIT
  } state_e;

  localparam int unsigned CFG_DIM_W     = 7;
  localparam int unsigned COST_ONE      = 256;
  localparam logic [6:0]  GRID_DIM_RST  = 7'd64;
  localparam logic [63:0] REVISION_RST  = 64'd1;

  // Neighbour order: N, W, E, S, NW, NE, SW, SE.
  localparam logic signed [1:0] STEP_DX [8] = '{2'sd0, -2'sd1, 2'sd1, 2'sd0,
                                                -2'sd1, 2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, 2'sd0, 2'sd0, 2'sd1,
                                                -2'sd1, -2'sd1, 2'sd1, 2'sd1};

endpackage

@@ hdl/navigation_grid_neighbor_store_top.sv @@
// Top level of the navigation grid neighbour store: cell memory, revision
// counter, configuration registers and the item sequencer.
// Depends on ngns_pkg.
//
// Usage: items enter on in_valid_i/in_ready_o as an in_item_t and results
// leave on out_valid_o/out_ready_i as an out_item_t; the grid size and the
// connectivity are set through the APB-style register port.
// After reset the block sweeps the whole cell memory, one cell per cycle,
// MAX_WIDTH*MAX_HEIGHT cells (4096 by default), setting every cell to
// walkable with cost 1.0; in_ready_o stays low during the sweep, while
// register writes are taken at any time.
// One item is worked on at a time; the single memory read port and the one
// result per cycle on the output set its length. For a read or a write, the
// cycle of acceptance issues the memory read; ST_CELL then checks the data,
// writes back and loads the output register once that register is free. A
// neighbour query reads its four or eight neighbours one per cycle, passes
// through ST_NCOLLECT and emits one result per cycle while the output is
// taken, at least one. The next item is accepted while the last result still
// waits; an output stall holds the sequencer only when it has a further
// result to load.
module navigation_grid_neighbor_store_top
  import ngns_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned COST_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned EW    = COST_BITS + 1;
  localparam logic [COST_BITS-1:0] RST_COST =
    (COST_BITS > 8) ? COST_BITS'(COST_ONE) : {COST_BITS{1'b1}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  // Configuration registers.
  logic [CFG_DIM_W-1:0] grid_width_q, grid_height_q;
  logic                 eight_way_q, corner_cutting_q;
  logic                 cfg_we;
  logic [CFG_DIM_W-1:0] eff_w, eff_h;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q     <= GRID_DIM_RST;
      grid_height_q    <= GRID_DIM_RST;
      eight_way_q      <= 1'b0;
      corner_cutting_q <= 1'b0;
    end else if (cfg_we) begin
      case (reg_e'(paddr[3:2]))
        REG_GRID_WIDTH:     grid_width_q     <= pwdata[CFG_DIM_W-1:0];
        REG_GRID_HEIGHT:    grid_height_q    <= pwdata[CFG_DIM_W-1:0];
        REG_EIGHT_WAY:      eight_way_q      <= pwdata[0];
        REG_CORNER_CUTTING: corner_cutting_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_GRID_WIDTH:     prdata = 32'(grid_width_q);
      REG_GRID_HEIGHT:    prdata = 32'(grid_height_q);
      REG_EIGHT_WAY:      prdata = 32'(eight_way_q);
      REG_CORNER_CUTTING: prdata = 32'(corner_cutting_q);
      default:            prdata = '0;
    endcase
  end

  // A size of zero acts as one, a size above the maximum as the maximum.
  always_comb begin
    if (grid_width_q == '0) begin
      eff_w = CFG_DIM_W'(1);
    end else if (32'(grid_width_q) > MAX_WIDTH) begin
      eff_w = CFG_DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = grid_width_q;
    end
    if (grid_height_q == '0) begin
      eff_h = CFG_DIM_W'(1);
    end else if (32'(grid_height_q) > MAX_HEIGHT) begin
      eff_h = CFG_DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height_q;
    end
  end

  function automatic logic in_grid(input logic signed [16:0] cx,
                                   input logic signed [16:0] cy,
                                   input logic [CFG_DIM_W-1:0] w,
                                   input logic [CFG_DIM_W-1:0] h);
    return !cx[16] && !cy[16] &&
           (cx[15:0] < 16'(w)) && (cy[15:0] < 16'(h));
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [16:0] cx,
                                              input logic signed [16:0] cy);
    return AW'(32'(cy[CFG_DIM_W-1:0]) * MAX_WIDTH + 32'(cx[CFG_DIM_W-1:0]));
  endfunction

  // Cell memory: walkable bit on top, cost below.
  logic [EW-1:0] grid_mem_q [CELLS];
  logic [EW-1:0] rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [EW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= grid_mem_q[mem_raddr];
    end
  end

  // Sequencer state.
  state_e                state_q, state_d;
  in_item_t              item_q;
  logic                  inside_q;
  logic [AW-1:0]         clr_q, clr_d;
  logic [2:0]            k_q, k_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [2:0]            rd_k_q, rd_k_d;
  logic                  rd_inr_q, rd_inr_d;
  logic [7:0]            walk_q, walk_d;
  logic [7:0]            sent_q, sent_d;
  logic [63:0]           rev_q, rev_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic                  out_load;

  logic                  accept;
  logic signed [16:0]    in_x, in_y, x_q17, y_q17, nb_x, nb_y;
  logic                  in_inside, nb_inr;
  logic                  out_free;
  logic [COST_BITS-1:0]  in_cost, cur_cost, new_cost;
  logic                  cur_walk, new_walk, wr_valid, wr_change, is_write;
  logic [63:0]           rev_inc;
  logic [7:0]            cand, remaining, pick, rest;
  logic [2:0]            pick_idx;
  logic signed [16:0]    emit_x, emit_y;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign in_x      = 17'(in_item_i.cell_x);
  assign in_y      = 17'(in_item_i.cell_y);
  assign in_inside = in_grid(in_x, in_y, eff_w, eff_h);
  assign x_q17     = 17'(item_q.cell_x);
  assign y_q17     = 17'(item_q.cell_y);
  assign nb_x      = x_q17 + 17'(STEP_DX[k_q]);
  assign nb_y      = y_q17 + 17'(STEP_DY[k_q]);
  assign nb_inr    = in_grid(nb_x, nb_y, eff_w, eff_h);

  // Read-modify-write of one cell.
  assign in_cost  = COST_BITS'(item_q.new_cost);
  assign cur_walk = rdata_q[COST_BITS];
  assign cur_cost = rdata_q[COST_BITS-1:0];
  always_comb begin
    new_walk = cur_walk;
    new_cost = cur_cost;
    is_write = 1'b0;
    case (op_e'(item_q.op))
      OP_WRITE_CELL: begin
        new_walk = item_q.new_walkable;
        new_cost = in_cost;
        is_write = 1'b1;
      end
      OP_WRITE_WALK: begin
        new_walk = item_q.new_walkable;
        is_write = 1'b1;
      end
      OP_WRITE_COST: begin
        new_cost = in_cost;
        is_write = 1'b1;
      end
      default: ;
    endcase
  end
  assign wr_valid  = is_write && inside_q && (new_cost != '0);
  assign wr_change = (new_walk != cur_walk) || (new_cost != cur_cost);
  // The revision counter skips zero when it wraps.
  assign rev_inc   = (rev_q == 64'hFFFF_FFFF_FFFF_FFFF) ? 64'd1 : rev_q + 64'd1;

  // Neighbour selection. A diagonal without corner cutting also needs both
  // orthogonal cells that flank it to be walkable.
  always_comb begin
    cand[3:0] = walk_q[3:0];
    cand[4]   = walk_q[4] & (corner_cutting_q | (walk_q[1] & walk_q[0]));
    cand[5]   = walk_q[5] & (corner_cutting_q | (walk_q[2] & walk_q[0]));
    cand[6]   = walk_q[6] & (corner_cutting_q | (walk_q[1] & walk_q[3]));
    cand[7]   = walk_q[7] & (corner_cutting_q | (walk_q[2] & walk_q[3]));
    if (!eight_way_q) begin
      cand[7:4] = '0;
    end
  end
  assign remaining = cand & ~sent_q;
  assign pick      = remaining & (~remaining + 8'd1);
  assign rest      = remaining & ~pick;
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (pick[i]) begin
        pick_idx = 3'(i);
      end
    end
  end
  assign emit_x = x_q17 + 17'(STEP_DX[pick_idx]);
  assign emit_y = y_q17 + 17'(STEP_DY[pick_idx]);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    rd_pend_d   = 1'b0;
    rd_k_d      = rd_k_q;
    rd_inr_d    = rd_inr_q;
    walk_d      = walk_q;
    sent_d      = sent_q;
    rev_d       = rev_q;
    out_load    = 1'b0;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = {1'b1, RST_COST};

    if (rd_pend_q) begin
      walk_d[rd_k_q] = rd_inr_q & rdata_q[COST_BITS];
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          walk_d = '0;
          sent_d = '0;
          k_d    = '0;
          if (op_e'(in_item_i.op) == OP_NEIGHBORS) begin
            state_d = ST_NREAD;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = in_inside ? cell_addr(in_x, in_y) : '0;
            state_d   = ST_CELL;
          end
        end
      end
      ST_CELL: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = '0;
          out_d.last = 1'b1;
          if (wr_valid && wr_change) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(x_q17, y_q17);
            mem_wdata = {new_walk, new_cost};
            rev_d     = rev_inc;
          end
          out_d.revision = (wr_valid && wr_change) ? rev_inc : rev_q;
          case (op_e'(item_q.op))
            OP_READ: begin
              out_d.ok            = inside_q;
              out_d.cell_walkable = inside_q & cur_walk;
              out_d.cell_cost     = inside_q ? 16'(cur_cost) : '0;
            end
            OP_WRITE_CELL, OP_WRITE_WALK, OP_WRITE_COST: begin
              out_d.ok = wr_valid;
            end
            default: ;
          endcase
          state_d = ST_IDLE;
        end
      end
      ST_NREAD: begin
        mem_re    = 1'b1;
        mem_raddr = nb_inr ? cell_addr(nb_x, nb_y) : '0;
        rd_pend_d = 1'b1;
        rd_k_d    = k_q;
        rd_inr_d  = nb_inr;
        k_d       = k_q + 3'd1;
        if (k_q == (eight_way_q ? 3'd7 : 3'd3)) begin
          state_d = ST_NCOLLECT;
        end
      end
      ST_NCOLLECT: begin
        state_d = ST_NEMIT;
      end
      ST_NEMIT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d            = '0;
          out_d.ok         = inside_q;
          out_d.found      = |remaining;
          out_d.neighbor_x = (|remaining) ? emit_x[5:0] : '0;
          out_d.neighbor_y = (|remaining) ? emit_y[5:0] : '0;
          out_d.last       = (rest == '0);
          out_d.revision   = rev_q;
          sent_d           = sent_q | pick;
          if (rest == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      rd_k_q      <= '0;
      rd_inr_q    <= 1'b0;
      walk_q      <= '0;
      sent_q      <= '0;
      rev_q       <= REVISION_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      rd_pend_q   <= rd_pend_d;
      rd_k_q      <= rd_k_d;
      rd_inr_q    <= rd_inr_d;
      walk_q      <= walk_d;
      sent_q      <= sent_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q   <= in_item_i;
      inside_q <= in_inside;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_rev_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rev_q != 64'd0)
    else $error("revision counter reached zero");

  a_mem_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_CELL))
    else $error("cell memory written outside the clear sweep or a cell update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while holding an untaken item");

  a_sent_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEMIT) |-> ((sent_q & ~cand) == 8'd0))
    else $error("emitted a neighbour that is not a candidate");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after loading the final result");
`endif

endmodule
